/* sv/cfb_pkg.sv */
// shared types and constants of the clipped framebuffer fill block
// no dependencies
package cfb_pkg;

   localparam int COORD_W = 16;
   localparam int COLOR_W = 8;
   localparam int DIM_W   = 9;
   // wide enough for a corner sum of two 16-bit operands, with sign
   localparam int EXT_W   = 18;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic [2:0] {
      ACT_CLEAR = 3'd0,
      ACT_FILL  = 3'd1,
      ACT_HLINE = 3'd2,
      ACT_VLINE = 3'd3,
      ACT_WRITE = 3'd4,
      ACT_READ  = 3'd5
   } action_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] alpha;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

endpackage

/* sv/cfb_store.sv */
// pixel store: one write port, one read port with registered read data
// depends on cfb_pkg for the pixel type
module cfb_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  cfb_pkg::pixel_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output cfb_pkg::pixel_type  rd_data
);

   cfb_pkg::pixel_type mem [DEPTH];
   cfb_pkg::pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/clipped_framebuffer_fill.sv */
// clipped framebuffer fill: clear, rectangle fill, lines, pixel write and read
// on a packed ARGB surface; depends on cfb_pkg and cfb_store
//
// usage
//   req_* carries one command per transaction (valid/ready); every command
//   gives exactly one transaction on rsp_* (valid/ready), in order. only a
//   pixel read returns a nonzero pixel; all other commands return zero.
//   csr_* writes surface_width (index 0) or surface_height (index 1); it is
//   always ready and should only be used while no command is outstanding.
// timing
//   a command is clipped at acceptance, then walks its clipped area at one
//   pixel write per cycle through the single store write port. a command
//   touching N pixels keeps req_ready low through setup, N writes and the
//   result; an empty command goes straight to the result, and a read passes
//   through setup, a store read and the result.
// reset
//   synchronous reset starts a clearing pass over all MAX_WIDTH*MAX_HEIGHT
//   words, one per cycle; req_ready stays low until it finishes. both
//   dimension registers return to 256.
// stall
//   a finished result waits in the rsp register; a new command can be taken
//   meanwhile, and it waits before delivering its own result until rsp frees.
module clipped_framebuffer_fill #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_action,
   input  logic signed [cfb_pkg::COORD_W-1:0] req_first_x,
   input  logic signed [cfb_pkg::COORD_W-1:0] req_first_y,
   input  logic signed [cfb_pkg::COORD_W-1:0] req_second_x,
   input  logic signed [cfb_pkg::COORD_W-1:0] req_second_y,
   input  logic [cfb_pkg::COLOR_W-1:0]        req_color_alpha,
   input  logic [cfb_pkg::COLOR_W-1:0]        req_color_red,
   input  logic [cfb_pkg::COLOR_W-1:0]        req_color_green,
   input  logic [cfb_pkg::COLOR_W-1:0]        req_color_blue,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cfb_pkg::COLOR_W-1:0]        rsp_read_alpha,
   output logic [cfb_pkg::COLOR_W-1:0]        rsp_read_red,
   output logic [cfb_pkg::COLOR_W-1:0]        rsp_read_green,
   output logic [cfb_pkg::COLOR_W-1:0]        rsp_read_blue,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [cfb_pkg::DIM_W-1:0]          csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int EW    = cfb_pkg::EXT_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_FILL,
      ST_READ,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [cfb_pkg::DIM_W-1:0] width_ff, width_in;
   logic [cfb_pkg::DIM_W-1:0] height_ff, height_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         row_base_ff, row_base_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [XW-1:0]         x1_ff, x1_in;
   logic [XW-1:0]         x2_ff, x2_in;
   logic [YW-1:0]         y_ff, y_in;
   logic [YW-1:0]         y2_ff, y2_in;
   logic                  read_ff, read_in;
   cfb_pkg::pixel_type    color_ff, color_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfb_pkg::pixel_type    rsp_pix_ff, rsp_pix_in;

   logic [XW-1:0]         eff_w;
   logic [YW-1:0]         eff_h;
   logic                  req_take;
   logic                  dec_draw;
   logic                  dec_read;
   logic signed [EW-1:0]  dec_x1, dec_x2, dec_y1, dec_y2;
   logic [YW+XW-1:0]      prod;
   logic [AW-1:0]         pix_addr;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   cfb_pkg::pixel_type    wr_data;
   logic                  rd_en;
   cfb_pkg::pixel_type    rd_data;

   // dimensions above the store size are taken as the store size
   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = XW'(MAX_WIDTH);
      end else begin
         eff_w = XW'(width_ff);
      end
      if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = YW'(MAX_HEIGHT);
      end else begin
         eff_h = YW'(height_ff);
      end
   end

   // clip the command to a half-open rectangle [x1,x2) x [y1,y2)
   always_comb begin
      logic signed [EW-1:0] ax, ay, bx, by, sw, sh, lo, hi;
      ax = EW'(req_first_x);
      ay = EW'(req_first_y);
      bx = EW'(req_second_x);
      by = EW'(req_second_y);
      sw = $signed(EW'(eff_w));
      sh = $signed(EW'(eff_h));
      lo = '0;
      hi = '0;
      dec_x1   = ax;
      dec_y1   = ay;
      dec_x2   = ax + EW'(1);
      dec_y2   = ay + EW'(1);
      dec_draw = 1'b0;
      dec_read = 1'b0;
      unique case (cfb_pkg::action_type'(req_action))
         cfb_pkg::ACT_CLEAR: begin
            dec_x1   = '0;
            dec_y1   = '0;
            dec_x2   = sw;
            dec_y2   = sh;
            dec_draw = (sw > 0) && (sh > 0);
         end
         cfb_pkg::ACT_FILL: begin
            dec_x1   = (ax < 0) ? '0 : ax;
            dec_y1   = (ay < 0) ? '0 : ay;
            dec_x2   = (ax + bx > sw) ? sw : ax + bx;
            dec_y2   = (ay + by > sh) ? sh : ay + by;
            dec_draw = (dec_x1 < dec_x2) && (dec_y1 < dec_y2);
         end
         cfb_pkg::ACT_HLINE: begin
            lo       = (ax < bx) ? ax : bx;
            hi       = (ax < bx) ? bx : ax;
            dec_x1   = (lo < 0) ? '0 : lo;
            dec_x2   = (hi + EW'(1) > sw) ? sw : hi + EW'(1);
            dec_draw = (ay >= 0) && (ay < sh) && (dec_x1 < dec_x2);
         end
         cfb_pkg::ACT_VLINE: begin
            lo       = (ay < by) ? ay : by;
            hi       = (ay < by) ? by : ay;
            dec_y1   = (lo < 0) ? '0 : lo;
            dec_y2   = (hi + EW'(1) > sh) ? sh : hi + EW'(1);
            dec_draw = (ax >= 0) && (ax < sw) && (dec_y1 < dec_y2);
         end
         cfb_pkg::ACT_WRITE: begin
            dec_draw = (ax >= 0) && (ay >= 0) && (ax < sw) && (ay < sh);
         end
         cfb_pkg::ACT_READ: begin
            dec_read = (ax >= 0) && (ay >= 0) && (ax < sw) && (ay < sh);
         end
         default: begin
            dec_draw = 1'b0;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign prod     = {XW'(0), y_ff} * {YW'(0), eff_w};
   assign pix_addr = row_base_ff + AW'(x_ff);

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      clr_in       = clr_ff;
      row_base_in  = row_base_ff;
      x_in         = x_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y_in         = y_ff;
      y2_in        = y2_ff;
      read_in      = read_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rd_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (cfb_pkg::csr_index_type'(csr_index))
            cfb_pkg::CSR_WIDTH:  width_in  = csr_data;
            cfb_pkg::CSR_HEIGHT: height_in = csr_data;
            default:             width_in  = width_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               x_in     = dec_x1[XW-1:0];
               x1_in    = dec_x1[XW-1:0];
               x2_in    = dec_x2[XW-1:0];
               y_in     = dec_y1[YW-1:0];
               y2_in    = dec_y2[YW-1:0];
               read_in  = dec_read;
               color_in = {req_color_alpha, req_color_red, req_color_green,
                           req_color_blue};
               state_in = (dec_draw || dec_read) ? ST_SETUP : ST_DONE;
            end
         end
         ST_SETUP: begin
            row_base_in = prod[AW-1:0];
            state_in    = read_ff ? ST_READ : ST_FILL;
         end
         ST_FILL: begin
            if (x_ff + XW'(1) == x2_ff) begin
               x_in        = x1_ff;
               y_in        = y_ff + YW'(1);
               row_base_in = row_base_ff + AW'(eff_w);
               if (y_ff + YW'(1) == y2_ff) begin
                  state_in = ST_DONE;
               end
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = read_ff ? rd_data : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         width_ff     <= cfb_pkg::DIM_RESET;
         height_ff    <= cfb_pkg::DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_base_ff <= row_base_in;
      x_ff        <= x_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      y_ff        <= y_in;
      y2_ff       <= y2_in;
      read_ff     <= read_in;
      color_ff    <= color_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   // the clearing pass and the fill walk share the single write port
   assign wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_FILL);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : pix_addr;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : color_ff;

   cfb_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pix_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_alpha = rsp_pix_ff.alpha;
   assign rsp_read_red   = rsp_pix_ff.red;
   assign rsp_read_green = rsp_pix_ff.green;
   assign rsp_read_blue  = rsp_pix_ff.blue;

endmodule

/* sv/cfb_checker.sv */
// port-level checks for clipped_framebuffer_fill, bound to the top level
// depends on cfb_pkg for the color width
module cfb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cfb_pkg::COLOR_W-1:0] rsp_read_alpha,
   input logic [cfb_pkg::COLOR_W-1:0] rsp_read_red,
   input logic [cfb_pkg::COLOR_W-1:0] rsp_read_green,
   input logic [cfb_pkg::COLOR_W-1:0] rsp_read_blue
);

   logic [1:0] outst_ff, outst_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // transactions accepted but not yet answered
   always_comb begin
      outst_in = outst_ff;
      if (req_take && !rsp_take) begin
         outst_in = outst_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         outst_in = outst_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   // the clearing pass holds off commands right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("second command accepted while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_alpha)
         && $stable(rsp_read_red) && $stable(rsp_read_green)
         && $stable(rsp_read_blue))
      else $error("stalled response changed");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 2'd0)
      else $error("response without an accepted command");

   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff != 2'd3)
      else $error("more than two commands outstanding");

endmodule

bind clipped_framebuffer_fill cfb_checker u_cfb_checker (.*);
